@@ rtl/pfc_pkg.sv @@
`default_nettype none

package pfc_pkg;

    localparam int CHANS = 3;

    // Channel order inside the pipeline.
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef enum logic [2:0] {
        FMT_RGBA    = 3'd0,
        FMT_RGB     = 3'd1,
        FMT_MASK    = 3'd2,
        FMT_ARGB    = 3'd3,
        FMT_BGRA    = 3'd4,
        FMT_BGRA_PM = 3'd5
    } fmt_t;

    typedef enum logic [0:0] {
        REG_SOURCE_FORMAT = 1'b0,
        REG_TARGET_FORMAT = 1'b1
    } reg_idx_t;

    localparam logic [2:0] NBYTES_MASK = 3'd1;
    localparam logic [2:0] NBYTES_RGB  = 3'd3;
    localparam logic [2:0] NBYTES_FULL = 3'd4;

    // Grey weights and a reciprocal of 100 that is exact for sums up to 25500.
    localparam logic [14:0] GREY_WR     = 15'd30;
    localparam logic [14:0] GREY_WG     = 15'd59;
    localparam logic [14:0] GREY_WB     = 15'd11;
    localparam logic [29:0] GREY_RECIP  = 30'd20972;
    localparam int          GREY_SHIFT  = 21;
    localparam logic [14:0] GREY_MAXSUM = 15'd25500;

    // Restoring division state for one channel of the unpremultiply.
    typedef struct packed {
        logic [7:0] rem;     // partial remainder, below the divisor unless the channel saturates
        logic [7:0] num_lo;  // numerator bits not yet shifted in, MSB first
        logic [7:0] quo;     // quotient bits produced so far
        logic       sat;     // channel at or above alpha: result saturates
    } div_lane_t;

    // Four restoring division steps.
    function automatic div_lane_t div_step4(div_lane_t lane, logic [7:0] den);
        div_lane_t  o;
        logic [8:0] r;
        o = lane;
        for (int i = 0; i < 4; i++)
        begin
            r = {o.rem, o.num_lo[7]};
            o.num_lo = {o.num_lo[6:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                o.quo = {o.quo[6:0], 1'b1};
            end
            else
            begin
                o.quo = {o.quo[6:0], 1'b0};
            end
            o.rem = r[7:0];
        end
        return o;
    endfunction

    // floor(x / 255), exact for x below 65280.
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pixel_format_converter.sv @@
// Five register stages: decode, two divider stages, resolve, and target layout.
// Throughput: one pixel per cycle while m_tready is high; each stage holds its pixel only while the
// next stage is full, so bubbles close up under backpressure.
// Depth is set by the eight-bit unpremultiply divider, four quotient bits per stage.
// Reset clears all stage valid bits and sets both formats to RGBA.
`default_nettype none

module pixel_format_converter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // in_byte0, in_byte1, in_byte2, in_byte3
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata   // out_byte0..out_byte3, out_bytes, zero pad
);

    localparam int NC = pfc_pkg::CHANS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] source_format_reg;
    logic [2:0] target_format_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= pfc_pkg::FMT_RGBA;
            target_format_reg <= pfc_pkg::FMT_RGBA;
        end
        else if (cfg_write)
        begin
            unique case (pfc_pkg::reg_idx_t'(paddr[2]))
                pfc_pkg::REG_SOURCE_FORMAT: source_format_reg <= pwdata[2:0];
                pfc_pkg::REG_TARGET_FORMAT: target_format_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (pfc_pkg::reg_idx_t'(paddr[2]))
            pfc_pkg::REG_SOURCE_FORMAT: prdata = {29'd0, source_format_reg};
            pfc_pkg::REG_TARGET_FORMAT: prdata = {29'd0, target_format_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [5:1] valid_reg;
    logic [5:1] rdy;

    always_comb
    begin
        rdy[5] = !valid_reg[5] || m_tready;
        for (int k = 4; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1]) valid_reg[1] <= s_tvalid;
            for (int k = 2; k <= 5; k++)
            begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode source layout, set up the divider
    // ------------------------------------------------------------------
    logic [7:0] in_b0, in_b1, in_b2, in_b3;
    logic [NC-1:0][7:0] s1_chan_next;
    logic [7:0]         s1_a_next;
    logic               s1_pm_next;
    pfc_pkg::div_lane_t [NC-1:0] s1_lane_next;

    logic [NC-1:0][7:0] s1_chan_reg;
    logic [7:0]         s1_a_reg;
    logic               s1_pm_reg;
    pfc_pkg::div_lane_t [NC-1:0] s1_lane_reg;

    assign in_b0 = s_tdata[7:0];
    assign in_b1 = s_tdata[15:8];
    assign in_b2 = s_tdata[23:16];
    assign in_b3 = s_tdata[31:24];

    always_comb
    begin
        logic [15:0] num;
        s1_pm_next = 1'b0;
        unique case (pfc_pkg::fmt_t'(source_format_reg))
            pfc_pkg::FMT_RGB:
            begin
                s1_chan_next = {in_b2, in_b1, in_b0};
                s1_a_next    = 8'hFF;
            end
            pfc_pkg::FMT_MASK:
            begin
                s1_chan_next = {in_b0, in_b0, in_b0};
                s1_a_next    = 8'hFF;
            end
            pfc_pkg::FMT_ARGB:
            begin
                s1_chan_next = {in_b3, in_b2, in_b1};
                s1_a_next    = in_b0;
            end
            pfc_pkg::FMT_BGRA:
            begin
                s1_chan_next = {in_b0, in_b1, in_b2};
                s1_a_next    = in_b3;
            end
            pfc_pkg::FMT_BGRA_PM:
            begin
                s1_chan_next = {in_b0, in_b1, in_b2};
                s1_a_next    = in_b3;
                s1_pm_next   = 1'b1;
            end
            default:
            begin
                s1_chan_next = {in_b2, in_b1, in_b0};
                s1_a_next    = in_b3;
            end
        endcase
        // Numerator c*255; when c is below alpha the quotient fits in 8 bits
        // and the upper numerator byte is already below the divisor.
        for (int i = 0; i < NC; i++)
        begin
            num = {s1_chan_next[i], 8'd0} - {8'd0, s1_chan_next[i]};
            s1_lane_next[i].rem    = num[15:8];
            s1_lane_next[i].num_lo = num[7:0];
            s1_lane_next[i].quo    = 8'd0;
            s1_lane_next[i].sat    = s1_chan_next[i] >= s1_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && s_tvalid)
        begin
            s1_chan_reg <= s1_chan_next;
            s1_a_reg    <= s1_a_next;
            s1_pm_reg   <= s1_pm_next;
            s1_lane_reg <= s1_lane_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: unpremultiply divider
    // ------------------------------------------------------------------
    logic [NC-1:0][7:0] s2_chan_reg, s3_chan_reg;
    logic [7:0]         s2_a_reg, s3_a_reg;
    logic               s2_pm_reg, s3_pm_reg;
    pfc_pkg::div_lane_t [NC-1:0] s2_lane, s3_lane;
    logic               s2_en, s3_en;

    assign s2_en = rdy[2] && valid_reg[1];
    assign s3_en = rdy[3] && valid_reg[2];

    pfc_div_stage u_div_hi
    (
        .clk      (clk),
        .en       (s2_en),
        .den      (s1_a_reg),
        .lane_in  (s1_lane_reg),
        .lane_out (s2_lane)
    );

    pfc_div_stage u_div_lo
    (
        .clk      (clk),
        .en       (s3_en),
        .den      (s2_a_reg),
        .lane_in  (s2_lane),
        .lane_out (s3_lane)
    );

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_chan_reg <= s1_chan_reg;
            s2_a_reg    <= s1_a_reg;
            s2_pm_reg   <= s1_pm_reg;
        end
        if (s3_en)
        begin
            s3_chan_reg <= s2_chan_reg;
            s3_a_reg    <= s2_a_reg;
            s3_pm_reg   <= s2_pm_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: resolve RGBA, form premultiply products and grey sum
    // ------------------------------------------------------------------
    logic [NC-1:0][7:0]  s4_chan_next, s4_chan_reg;
    logic [NC-1:0][15:0] s4_prod_next, s4_prod_reg;
    logic [14:0]         s4_gsum_next, s4_gsum_reg;
    logic [7:0]          s4_a_reg;
    logic                s4_en;

    assign s4_en = rdy[4] && valid_reg[3];

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            if (!s3_pm_reg)
                s4_chan_next[i] = s3_chan_reg[i];
            else if (s3_a_reg == 8'd0)
                s4_chan_next[i] = 8'd0;   // fully transparent decodes as black
            else if (s3_lane[i].sat)
                s4_chan_next[i] = 8'hFF;
            else
                s4_chan_next[i] = s3_lane[i].quo;
            s4_prod_next[i] = {8'd0, s4_chan_next[i]} * {8'd0, s3_a_reg};
        end
        s4_gsum_next = {7'd0, s4_chan_next[pfc_pkg::CH_R]} * pfc_pkg::GREY_WR
                     + {7'd0, s4_chan_next[pfc_pkg::CH_G]} * pfc_pkg::GREY_WG
                     + {7'd0, s4_chan_next[pfc_pkg::CH_B]} * pfc_pkg::GREY_WB;
    end

    always_ff @(posedge clk)
    begin
        if (s4_en)
        begin
            s4_chan_reg <= s4_chan_next;
            s4_prod_reg <= s4_prod_next;
            s4_gsum_reg <= s4_gsum_next;
            s4_a_reg    <= s3_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: constant divisions and target layout
    // ------------------------------------------------------------------
    logic [NC-1:0][7:0] pm_chan;
    logic [29:0]        grey_mul;
    logic [7:0]         grey;
    logic [7:0]         o0_next, o1_next, o2_next, o3_next;
    logic [2:0]         nbytes_next;
    logic [7:0]         o0_reg, o1_reg, o2_reg, o3_reg;
    logic [2:0]         nbytes_reg;
    logic [7:0]         r4, g4, b4;

    assign r4 = s4_chan_reg[pfc_pkg::CH_R];
    assign g4 = s4_chan_reg[pfc_pkg::CH_G];
    assign b4 = s4_chan_reg[pfc_pkg::CH_B];

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            pm_chan[i] = pfc_pkg::div255(s4_prod_reg[i]);
        end
        grey_mul = {15'd0, s4_gsum_reg} * pfc_pkg::GREY_RECIP;
        grey     = grey_mul[pfc_pkg::GREY_SHIFT +: 8];
    end

    always_comb
    begin
        o1_next = 8'd0;
        o2_next = 8'd0;
        o3_next = 8'd0;
        unique case (pfc_pkg::fmt_t'(target_format_reg))
            pfc_pkg::FMT_RGB:
            begin
                o0_next = r4;
                o1_next = g4;
                o2_next = b4;
                nbytes_next = pfc_pkg::NBYTES_RGB;
            end
            pfc_pkg::FMT_MASK:
            begin
                o0_next = grey;
                nbytes_next = pfc_pkg::NBYTES_MASK;
            end
            pfc_pkg::FMT_ARGB:
            begin
                o0_next = s4_a_reg;
                o1_next = r4;
                o2_next = g4;
                o3_next = b4;
                nbytes_next = pfc_pkg::NBYTES_FULL;
            end
            pfc_pkg::FMT_BGRA:
            begin
                o0_next = b4;
                o1_next = g4;
                o2_next = r4;
                o3_next = s4_a_reg;
                nbytes_next = pfc_pkg::NBYTES_FULL;
            end
            pfc_pkg::FMT_BGRA_PM:
            begin
                o0_next = pm_chan[pfc_pkg::CH_B];
                o1_next = pm_chan[pfc_pkg::CH_G];
                o2_next = pm_chan[pfc_pkg::CH_R];
                o3_next = s4_a_reg;
                nbytes_next = pfc_pkg::NBYTES_FULL;
            end
            default:
            begin
                o0_next = r4;
                o1_next = g4;
                o2_next = b4;
                o3_next = s4_a_reg;
                nbytes_next = pfc_pkg::NBYTES_FULL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5] && valid_reg[4])
        begin
            o0_reg     <= o0_next;
            o1_reg     <= o1_next;
            o2_reg     <= o2_next;
            o3_reg     <= o3_next;
            nbytes_reg <= nbytes_next;
        end
    end

    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {5'd0, nbytes_reg, o3_reg, o2_reg, o1_reg, o0_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input side only stalls when every stage holds a pixel.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (valid_reg == 5'b11111))
        else $error("input stalled with a bubble in the pipeline");

    a_nbytes_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (nbytes_reg == pfc_pkg::NBYTES_MASK ||
                          nbytes_reg == pfc_pkg::NBYTES_RGB ||
                          nbytes_reg == pfc_pkg::NBYTES_FULL))
        else $error("illegal output byte count");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && nbytes_reg != pfc_pkg::NBYTES_FULL) |->
        (o3_reg == 8'd0 &&
         (nbytes_reg != pfc_pkg::NBYTES_MASK || (o1_reg == 8'd0 && o2_reg == 8'd0))))
        else $error("output byte beyond the byte count is not zero");

    a_grey_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (s4_gsum_reg <= pfc_pkg::GREY_MAXSUM))
        else $error("grey sum out of range");

    // A stalled output stage keeps its pixel.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && !m_tready) |=> (valid_reg[5] && $stable(m_tdata)))
        else $error("pending result lost under backpressure");

endmodule

`default_nettype wire

@@ rtl/pfc_div_stage.sv @@
`default_nettype none

// One register stage of the unpremultiply divider: four quotient bits for
// each color channel, all sharing the alpha divisor.
module pfc_div_stage
(
    input  wire logic                                      clk,
    input  wire logic                                      en,
    input  wire logic [7:0]                                den,
    input  wire pfc_pkg::div_lane_t [pfc_pkg::CHANS-1:0]   lane_in,
    output pfc_pkg::div_lane_t      [pfc_pkg::CHANS-1:0]   lane_out
);

    pfc_pkg::div_lane_t [pfc_pkg::CHANS-1:0] lane_reg;
    pfc_pkg::div_lane_t [pfc_pkg::CHANS-1:0] lane_next;

    always_comb
    begin
        for (int i = 0; i < pfc_pkg::CHANS; i++)
        begin
            lane_next[i] = pfc_pkg::div_step4(lane_in[i], den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

@@ tb/tb_pixel_format_converter.sv @@
`timescale 1ns / 1ps

module tb_pixel_format_converter;

    localparam int PIPE_LATENCY = 5;
    localparam int MAX_REPORTS  = 10;

    // Codes with no defined layout; the block treats them as RGBA.
    localparam logic [2:0] FMT_UNDEF_LO = 3'd6;
    localparam logic [2:0] FMT_UNDEF_HI = 3'd7;

    // Packed so that it lines up with m_tdata[34:0].
    typedef struct packed {
        logic [2:0] nbytes;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } pixel_res_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // in_byte0, in_byte1, in_byte2, in_byte3
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // out_byte0..out_byte3, out_bytes, zero pad

    logic [2:0]  src_fmt_q = pfc_pkg::FMT_RGBA;
    logic [2:0]  dst_fmt_q = pfc_pkg::FMT_RGBA;

    pixel_res_t  pixel_exp_q[$];
    pixel_res_t  got_px;
    pixel_res_t  want_px;
    int          fail_cnt = 0;

    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          hold_len     = 0;
    int          hold_req_cnt = 0;

    pixel_format_converter DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] unpremultiply(int c, int a);
        int v;
        v = (c * 255) / a;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] premultiply(int c, int a);
        int v;
        v = (c * a) / 255;
        return v[7:0];
    endfunction

    function automatic pixel_res_t convert_pixel(logic [2:0] src, logic [2:0] dst,
                                                 logic [31:0] px);
        int b0, b1, b2, b3;
        int r, g, b, a;
        int grey;
        pixel_res_t res;
        b0 = int'(px[7:0]);
        b1 = int'(px[15:8]);
        b2 = int'(px[23:16]);
        b3 = int'(px[31:24]);
        case (src)
            pfc_pkg::FMT_RGB:     begin r = b0; g = b1; b = b2; a = 255; end
            pfc_pkg::FMT_MASK:    begin r = b0; g = b0; b = b0; a = 255; end
            pfc_pkg::FMT_ARGB:    begin r = b1; g = b2; b = b3; a = b0; end
            pfc_pkg::FMT_BGRA:    begin r = b2; g = b1; b = b0; a = b3; end
            pfc_pkg::FMT_BGRA_PM:
            begin
                // A fully transparent premultiplied pixel decodes to all zeros.
                if (b3 == 0)
                begin
                    r = 0; g = 0; b = 0; a = 0;
                end
                else
                begin
                    r = unpremultiply(b2, b3);
                    g = unpremultiply(b1, b3);
                    b = unpremultiply(b0, b3);
                    a = b3;
                end
            end
            default:     begin r = b0; g = b1; b = b2; a = b3; end
        endcase
        res = '0;
        case (dst)
            pfc_pkg::FMT_RGB:
            begin
                res.b0 = r[7:0]; res.b1 = g[7:0]; res.b2 = b[7:0];
                res.nbytes = pfc_pkg::NBYTES_RGB;
            end
            pfc_pkg::FMT_MASK:
            begin
                grey = (30 * r + 59 * g + 11 * b) / 100;
                res.b0 = grey[7:0];
                res.nbytes = pfc_pkg::NBYTES_MASK;
            end
            pfc_pkg::FMT_ARGB:
            begin
                res.b0 = a[7:0]; res.b1 = r[7:0]; res.b2 = g[7:0]; res.b3 = b[7:0];
                res.nbytes = pfc_pkg::NBYTES_FULL;
            end
            pfc_pkg::FMT_BGRA:
            begin
                res.b0 = b[7:0]; res.b1 = g[7:0]; res.b2 = r[7:0]; res.b3 = a[7:0];
                res.nbytes = pfc_pkg::NBYTES_FULL;
            end
            pfc_pkg::FMT_BGRA_PM:
            begin
                res.b0 = premultiply(b, a);
                res.b1 = premultiply(g, a);
                res.b2 = premultiply(r, a);
                res.b3 = a[7:0];
                res.nbytes = pfc_pkg::NBYTES_FULL;
            end
            default:
            begin
                res.b0 = r[7:0]; res.b1 = g[7:0]; res.b2 = b[7:0]; res.b3 = a[7:0];
                res.nbytes = pfc_pkg::NBYTES_FULL;
            end
        endcase
        return res;
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        px = $urandom;
        case ($urandom_range(9))
            0: px = px & 32'h00FF_FF00;                   // zero alpha in either slot
            1: px = 32'hFFFF_FFFF;
            2: px = 32'h0000_0000;
            3: px[31:24] = 8'($urandom_range(1, 8));      // tiny alpha, heavy saturation
            4: px[7:0] = 8'($urandom_range(1, 8));
            default: ;
        endcase
        return px;
    endfunction

    task automatic record_failure(input string msg);
        if (fail_cnt < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // Result checker: every accepted pixel on the master side against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_px = m_tdata[34:0];
            if (pixel_exp_q.size() == 0)
            begin
                record_failure($sformatf("unexpected pixel %h", got_px));
            end
            else
            begin
                want_px = pixel_exp_q.pop_front();
                if (got_px.b0 !== want_px.b0 || got_px.b1 !== want_px.b1 ||
                    got_px.b2 !== want_px.b2 || got_px.b3 !== want_px.b3 ||
                    got_px.nbytes !== want_px.nbytes)
                    record_failure($sformatf(
                        "pixel mismatch: expected b0..b3 %h %h %h %h n %0d, got %h %h %h %h n %0d",
                        want_px.b0, want_px.b1, want_px.b2, want_px.b3, want_px.nbytes,
                        got_px.b0, got_px.b1, got_px.b2, got_px.b3, got_px.nbytes));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test requests one.
    initial
    begin : sink_proc
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req_cnt)
            begin
                hold_seen = hold_req_cnt;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= !(sink_idle_on && $urandom_range(99) < 26);
            end
        end
    end

    // All tasks below start and end at a falling edge.
    task automatic send_pixel(input logic [31:0] px);
        while (src_idle_on && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixel_exp_q.insert(pixel_exp_q.size(), convert_pixel(src_fmt_q, dst_fmt_q, px));
        @(negedge clk);
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (pixel_exp_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
    endtask

    task automatic apb_write(input pfc_pkg::reg_idx_t idx, input logic [2:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {29'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == pfc_pkg::REG_SOURCE_FORMAT)
            src_fmt_q = val;
        else
            dst_fmt_q = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_formats(input logic [2:0] src, input logic [2:0] dst);
        drain_stream();
        apb_write(pfc_pkg::REG_SOURCE_FORMAT, src);
        apb_write(pfc_pkg::REG_TARGET_FORMAT, dst);
    endtask

    task automatic test_extremes();
        set_formats(pfc_pkg::FMT_RGBA, pfc_pkg::FMT_RGBA);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        set_formats(pfc_pkg::FMT_RGBA, pfc_pkg::FMT_MASK);
        send_pixel(32'hFFFF_FFFF);
    endtask

    // Each source and each target code once, the undefined codes included.
    task automatic test_format_sweep();
        for (int s = 0; s < 8; s++)
        begin
            set_formats(3'(s), 3'((s + 3) % 8));
            send_pixel(random_pixel());
            send_pixel($urandom);
        end
    endtask

    task automatic test_premultiplied_alpha();
        set_formats(pfc_pkg::FMT_BGRA_PM, pfc_pkg::FMT_ARGB);
        send_pixel(32'h00FF_FFFF);  // zero alpha
        send_pixel(32'h10FF_8011);  // color above alpha saturates
        send_pixel(32'h8080_8080);  // color equal to alpha
        set_formats(pfc_pkg::FMT_BGRA_PM, pfc_pkg::FMT_BGRA_PM);
        send_pixel(32'hFF12_34AB);
    endtask

    task automatic test_random_formats();
        logic [2:0] src;
        logic [2:0] dst;
        for (int phase = 0; phase < 36; phase++)
        begin
            src = 3'($urandom_range(7));
            dst = 3'($urandom_range(7));
            if (phase == 0)
            begin
                src = pfc_pkg::FMT_RGBA;
                dst = FMT_UNDEF_HI;
            end
            else if (phase == 1)
            begin
                src = FMT_UNDEF_HI;
                dst = pfc_pkg::FMT_RGBA;
            end
            else if (phase == 2)
            begin
                src = FMT_UNDEF_LO;
                dst = pfc_pkg::FMT_BGRA_PM;
            end
            set_formats(src, dst);
            for (int i = 0; i < 25; i++)
                send_pixel(random_pixel());
        end
    endtask

    task automatic test_steady_stream();
        set_formats(pfc_pkg::FMT_BGRA_PM, pfc_pkg::FMT_MASK);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < 100; i++)
            send_pixel(random_pixel());
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_formats(pfc_pkg::FMT_ARGB, pfc_pkg::FMT_BGRA_PM);
        // The receiver holds off long enough for the pipeline to fill and stall the input.
        src_idle_on  = 1'b0;
        hold_len     = 300;
        hold_req_cnt = hold_req_cnt + 1;
        for (int i = 0; i < 60; i++)
            send_pixel(random_pixel());
        src_idle_on = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pixel(random_pixel());
        // The sender pauses until everything is out, with no register change.
        drain_stream();
        for (int i = 0; i < 20; i++)
            send_pixel(random_pixel());
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_format_sweep();
        test_premultiplied_alpha();
        test_random_formats();
        test_steady_stream();
        test_backpressure();
        drain_stream();

        if (pixel_exp_q.size() != 0)
            record_failure($sformatf("%0d pixels never came out", pixel_exp_q.size()));
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pfc_pkg.sv
rtl/pfc_div_stage.sv
rtl/pixel_format_converter.sv
tb/tb_pixel_format_converter.sv
